// ----- rtl/soif_attribute_scanner_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the SOIF attribute scanner checker
// ----------------------------------------------------------------------------
`ifndef SOIF_ATTRIBUTE_SCANNER_CORE_MACROS_SVH
`define SOIF_ATTRIBUTE_SCANNER_CORE_MACROS_SVH

// Checked on every clock edge outside reset
`define SOIFS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define SOIFS_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/soifs_pkg.sv -----
// ----------------------------------------------------------------------------
// soifs_pkg
// Shared widths, codes, keyword tables and state types of the SOIF scanner.
// ----------------------------------------------------------------------------
package soifs_pkg;

    localparam int OFFSET_BITS   = 20;
    localparam int NAME_LEN_BITS = 7;
    localparam int STATUS_BITS   = 3;
    localparam int KW_COUNT      = 4;
    localparam int KW_IDX_BITS   = 4;
    localparam int KW_TEXT_BITS  = 72;

    localparam logic [NAME_LEN_BITS-1:0] MAX_NAME_CHARS = 7'd127;
    localparam logic [KW_IDX_BITS-1:0]   KW_IDX_MAX     = 4'd15;

    // Characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keyword index of the URL line; the others skip the record
    localparam logic [1:0] KW_FILE = 2'd0;

    // Keywords, right-justified in the text word
    localparam logic [KW_TEXT_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        KW_TEXT_BITS'("@FILE { "),
        KW_TEXT_BITS'("@DELETE "),
        KW_TEXT_BITS'("@REFRESH "),
        KW_TEXT_BITS'("@UPDATE")
    };
    localparam logic [KW_IDX_BITS-1:0] KW_LEN [KW_COUNT] = '{4'd8, 4'd8, 4'd9, 4'd7};

    typedef enum logic [3:0] {
        PH_SKIP    = 4'd0,
        PH_NAME    = 4'd1,
        PH_SIZE_WS = 4'd2,
        PH_DIGITS  = 4'd3,
        PH_COLON   = 4'd4,
        PH_DELIM   = 4'd5,
        PH_VALUE   = 4'd6,
        PH_NEWLINE = 4'd7,
        PH_URL     = 4'd8,
        PH_KWONLY  = 4'd9
    } t_phase;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ATTR      = 3'd0,
        ST_CLOSED    = 3'd1,
        ST_SKIPPED   = 3'd2,
        ST_BAD_START = 3'd3,
        ST_SPACE     = 3'd4,
        ST_BAD_TOKEN = 3'd5,
        ST_NO_NL     = 3'd6,
        ST_RAN_OUT   = 3'd7
    } t_status;

    typedef struct packed {
        t_phase                   phase;
        logic [OFFSET_BITS-1:0]   byte_offset;
        logic [KW_IDX_BITS-1:0]   kw_index;
        logic [KW_COUNT-1:0]      kw_cand;
        logic [OFFSET_BITS-1:0]   name_start;
        logic [NAME_LEN_BITS-1:0] name_length;
        logic [OFFSET_BITS-1:0]   size_acc;
        logic [OFFSET_BITS-1:0]   value_start;
        logic [OFFSET_BITS-1:0]   bytes_left;
        logic                     stopped;
        logic                     brace_first;
    } t_scan_state;

    typedef struct packed {
        t_status                  status;
        logic                     is_url;
        logic [OFFSET_BITS-1:0]   name_start;
        logic [NAME_LEN_BITS-1:0] name_length;
        logic [OFFSET_BITS-1:0]   value_start;
        logic [OFFSET_BITS-1:0]   value_end;
        logic                     final_res;
    } t_scan_result;

    localparam t_scan_state SCAN_RESET = '{phase: PH_SKIP, default: '0};

    // Whitespace: space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c != CH_NUL) && (c != CH_LBRACE) && (c != CH_COLON) &&
               (c != CH_LF) && (c != CH_SPACE) && (c != CH_TAB);
    endfunction

    // True when keyword k can no longer match with byte c at position idx
    function automatic logic kw_miss(input int k, input logic [KW_IDX_BITS-1:0] idx,
                                     input logic [7:0] c);
        logic [KW_IDX_BITS-1:0] pos;
        logic [7:0]             ch;
        if (idx >= KW_LEN[k]) begin
            return 1'b1;
        end
        pos = KW_LEN[k] - idx - 1'b1;
        ch  = KW_TEXT[k][{pos, 3'b000} +: 8];
        return ch != c;
    endfunction

endpackage

// ----- rtl/soifs_if.sv -----
// ----------------------------------------------------------------------------
// soifs_if
// Request and result channels of the SOIF scanner (valid/ready handshake).
// ----------------------------------------------------------------------------
interface soifs_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_record;

    modport source (output valid, output data_byte, output end_of_record, input ready);
    modport sink   (input valid, input data_byte, input end_of_record, output ready);
endinterface

interface soifs_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [soifs_pkg::STATUS_BITS-1:0]    status;
    logic                                 is_url;
    logic [soifs_pkg::OFFSET_BITS-1:0]    name_start;
    logic [soifs_pkg::NAME_LEN_BITS-1:0]  name_length;
    logic [soifs_pkg::OFFSET_BITS-1:0]    value_start;
    logic [soifs_pkg::OFFSET_BITS-1:0]    value_end;
    logic                                 final_res;

    modport source (output valid, output status, output is_url, output name_start,
                    output name_length, output value_start, output value_end,
                    output final_res, input ready);
    modport sink   (input valid, input status, input is_url, input name_start,
                    input name_length, input value_start, input value_end,
                    input final_res, output ready);
endinterface

// ----- rtl/soifs_feed.sv -----
// ----------------------------------------------------------------------------
// soifs_feed
// One byte step of the scanner: next state and at most one result.
// ----------------------------------------------------------------------------
module soifs_feed (
    input  soifs_pkg::t_scan_state  i_state,
    input  logic [7:0]              i_byte,
    output soifs_pkg::t_scan_state  o_state,
    output logic                    o_res_valid,
    output soifs_pkg::t_scan_result o_res
);
    import soifs_pkg::*;

    localparam int WIDE_BITS = OFFSET_BITS + 4;
    localparam logic [WIDE_BITS-1:0] SIZE_MAX = {4'b0000, {OFFSET_BITS{1'b1}}};

    logic [KW_COUNT-1:0]    kw_cand_n;
    logic [KW_IDX_BITS-1:0] kw_idx_n;
    logic                   kw_done;
    logic [1:0]             kw_hit;
    logic [WIDE_BITS-1:0]   size_wide;
    logic [OFFSET_BITS-1:0] size_n;
    logic [OFFSET_BITS-1:0] bytes_n;
    logic                   is_digit;
    logic                   do_bad;
    logic                   do_err;
    t_status                err_status;

    // Keyword match advance
    always_comb begin
        kw_done = 1'b0;
        kw_hit  = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_cand_n[k] = i_state.kw_cand[k] && !kw_miss(k, i_state.kw_index, i_byte);
        end
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (kw_cand_n[k] &&
                ({1'b0, i_state.kw_index} + 1'b1) == {1'b0, KW_LEN[k]}) begin
                kw_done = 1'b1;
                kw_hit  = 2'(k);
            end
        end
        kw_idx_n = (i_state.kw_index == KW_IDX_MAX) ? KW_IDX_MAX
                                                    : i_state.kw_index + 1'b1;
    end

    // Decimal size: acc * 10 + digit, saturating
    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign size_wide = {1'b0, i_state.size_acc, 3'b000}
                       + {3'b000, i_state.size_acc, 1'b0}
                       + {{(WIDE_BITS-8){1'b0}}, i_byte - CH_ZERO};
    assign size_n    = (size_wide > SIZE_MAX) ? {OFFSET_BITS{1'b1}}
                                              : size_wide[OFFSET_BITS-1:0];

    assign bytes_n = (i_state.bytes_left != '0) ? i_state.bytes_left - 1'b1
                                                : i_state.bytes_left;

    // Phase step
    always_comb begin
        o_state             = i_state;
        o_state.byte_offset = i_state.byte_offset + 1'b1;
        o_res_valid         = 1'b0;
        o_res               = '0;
        do_bad              = 1'b0;
        do_err              = 1'b0;
        err_status          = ST_BAD_TOKEN;

        if (!i_state.stopped) begin
            unique case (i_state.phase) inside
                PH_SKIP: begin
                    if (i_byte == CH_NUL) begin
                        o_state.stopped = 1'b1;
                    end else if (!is_ws(i_byte)) begin
                        o_state.name_start  = i_state.byte_offset;
                        o_state.name_length = '0;
                        o_state.brace_first = (i_byte == CH_RBRACE);
                        o_state.kw_cand     = (i_byte == CH_AT) ? '1 : '0;
                        o_state.kw_index    = KW_IDX_BITS'(1);
                        if (is_name_char(i_byte)) begin
                            o_state.name_length = NAME_LEN_BITS'(1);
                            o_state.phase       = PH_NAME;
                        end else begin
                            do_bad = 1'b1;
                        end
                    end
                end
                PH_NAME, PH_KWONLY: begin
                    if (i_state.kw_cand != '0) begin
                        o_state.kw_cand  = kw_cand_n;
                        o_state.kw_index = kw_idx_n;
                    end
                    if (i_state.kw_cand != '0 && kw_done && kw_hit == KW_FILE) begin
                        o_state.kw_cand     = '0;
                        o_state.value_start = i_state.byte_offset + 1'b1;
                        o_state.phase       = PH_URL;
                    end else if (i_state.kw_cand != '0 && kw_done) begin
                        do_err     = 1'b1;
                        err_status = ST_SKIPPED;
                    end else if (i_state.phase == PH_KWONLY) begin
                        do_bad = (o_state.kw_cand == '0);
                    end else if (is_name_char(i_byte) &&
                                 i_state.name_length < MAX_NAME_CHARS) begin
                        o_state.name_length = i_state.name_length + 1'b1;
                    end else if (i_byte == CH_LBRACE) begin
                        o_state.size_acc = '0;
                        o_state.phase    = PH_SIZE_WS;
                    end else if (o_state.kw_cand != '0) begin
                        o_state.phase = PH_KWONLY;
                    end else begin
                        do_bad = 1'b1;
                    end
                end
                PH_SIZE_WS, PH_DIGITS: begin
                    if (i_state.phase == PH_SIZE_WS && is_ws(i_byte)) begin
                        o_state.phase = PH_SIZE_WS;
                    end else if (is_digit) begin
                        o_state.size_acc = size_n;
                        o_state.phase    = PH_DIGITS;
                    end else if (i_state.phase == PH_DIGITS && i_byte == CH_RBRACE) begin
                        o_state.phase = PH_COLON;
                    end else begin
                        do_bad = 1'b1;
                    end
                end
                PH_COLON: begin
                    if (i_byte == CH_COLON) begin
                        o_state.phase = PH_DELIM;
                    end else begin
                        do_bad = 1'b1;
                    end
                end
                PH_DELIM: begin
                    if (i_byte == CH_TAB) begin
                        o_state.value_start = i_state.byte_offset + 1'b1;
                        o_state.bytes_left  = i_state.size_acc;
                        o_state.phase = (i_state.size_acc != '0) ? PH_VALUE : PH_NEWLINE;
                    end else if (i_byte == CH_SPACE) begin
                        do_err     = 1'b1;
                        err_status = ST_SPACE;
                    end else begin
                        do_bad = 1'b1;
                    end
                end
                PH_VALUE: begin
                    o_state.bytes_left = bytes_n;
                    if (bytes_n == '0) begin
                        o_state.phase = PH_NEWLINE;
                    end
                end
                PH_NEWLINE, PH_URL: begin
                    if (i_byte == CH_LF) begin
                        o_state.phase     = PH_SKIP;
                        o_res_valid       = 1'b1;
                        o_res.status      = ST_ATTR;
                        o_res.is_url      = (i_state.phase == PH_URL);
                        o_res.name_start  = i_state.name_start;
                        o_res.name_length = (i_state.phase == PH_URL) ? '0
                                                                      : i_state.name_length;
                        o_res.value_start = i_state.value_start;
                        o_res.value_end   = i_state.byte_offset - 1'b1;
                    end else if (i_state.phase == PH_NEWLINE) begin
                        do_err     = 1'b1;
                        err_status = ST_NO_NL;
                    end else if (i_byte == CH_NUL) begin
                        do_err     = 1'b1;
                        err_status = ST_BAD_START;
                    end
                end
                default: begin
                    o_state.phase = PH_SKIP;
                end
            endcase
        end

        // Bad token reports a brace close when the item began with a brace
        if (do_bad) begin
            do_err     = 1'b1;
            err_status = o_state.brace_first ? ST_CLOSED : ST_BAD_TOKEN;
        end
        if (do_err) begin
            o_state.stopped = 1'b1;
            o_res_valid     = 1'b1;
            o_res           = '0;
            o_res.status    = err_status;
            o_res.final_res = 1'b1;
        end
    end

endmodule

// ----- rtl/soif_attribute_scanner_core.sv -----
// A completing byte's result is registered into r_main, or into r_skid while r_main waits.
// Throughput: one byte per cycle while the skid entry is empty; the record-end byte runs
// two byte steps in the same state-update path (the byte itself, then an implied NUL).
// A two-entry output buffer keeps input flowing while one result waits.
// Reset (synchronous, active low) returns the scanner to whitespace skipping at offset 0
// and empties the output buffer.
// ----------------------------------------------------------------------------
// soif_attribute_scanner_core
// Scans SOIF record text byte by byte and reports attribute name and value spans.
// ----------------------------------------------------------------------------
module soif_attribute_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    soifs_req_if.sink   i_req,
    soifs_res_if.source o_res
);
    import soifs_pkg::*;

    t_scan_state  r_state;
    t_scan_state  n_state;
    t_scan_state  f1_state;
    t_scan_state  f2_state;
    t_scan_result f1_res;
    t_scan_result f2_res;
    t_scan_result new_res;
    t_scan_result r_main;
    t_scan_result r_skid;
    logic         f1_valid;
    logic         f2_valid;
    logic         new_valid;
    logic         r_main_valid;
    logic         r_skid_valid;
    logic         accept;
    logic         push;
    logic         pop;

    // Step for the incoming byte
    soifs_feed u_feed_byte (
        .i_state     (r_state),
        .i_byte      (i_req.data_byte),
        .o_state     (f1_state),
        .o_res_valid (f1_valid),
        .o_res       (f1_res)
    );

    // Implied NUL after the last byte of a record
    soifs_feed u_feed_end (
        .i_state     (f1_state),
        .i_byte      (CH_NUL),
        .o_state     (f2_state),
        .o_res_valid (f2_valid),
        .o_res       (f2_res)
    );

    // Result of this request: byte step first, then record-end handling
    always_comb begin
        new_valid = f1_valid;
        new_res   = f1_res;
        n_state   = f1_state;
        if (i_req.end_of_record) begin
            n_state = SCAN_RESET;
            if (!f1_valid && !f1_state.stopped) begin
                if (f1_state.phase == PH_VALUE) begin
                    new_valid           = 1'b1;
                    new_res             = '0;
                    new_res.status      = f1_state.brace_first ? ST_CLOSED : ST_RAN_OUT;
                    new_res.final_res   = 1'b1;
                end else begin
                    new_valid = f2_valid;
                    new_res   = f2_res;
                end
            end
        end
    end

    assign accept      = i_req.valid && i_req.ready;
    assign push        = accept && new_valid;
    assign pop         = r_main_valid && o_res.ready;
    assign i_req.ready = !r_skid_valid;

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= push;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= push;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_main <= r_skid;
        end else if (push && (pop || !r_main_valid)) begin
            r_main <= new_res;
        end
        if (push && r_main_valid && !pop) begin
            r_skid <= new_res;
        end
    end

    assign o_res.valid       = r_main_valid;
    assign o_res.status      = r_main.status;
    assign o_res.is_url      = r_main.is_url;
    assign o_res.name_start  = r_main.name_start;
    assign o_res.name_length = r_main.name_length;
    assign o_res.value_start = r_main.value_start;
    assign o_res.value_end   = r_main.value_end;
    assign o_res.final_res   = r_main.final_res;

endmodule

// ----- rtl/soifs_checker.sv -----
// ----------------------------------------------------------------------------
// soifs_checker
// Port-level checks of the SOIF scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "soif_attribute_scanner_core_macros.svh"

module soifs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_req_ready,
    input logic                                i_res_valid,
    input logic                                i_res_ready,
    input logic [soifs_pkg::STATUS_BITS-1:0]   i_status,
    input logic [soifs_pkg::OFFSET_BITS-1:0]   i_value_end
);
    import soifs_pkg::*;

    // A waiting result stays offered
    `SOIFS_CHECK(a_res_hold, i_res_valid && !i_res_ready |=> i_res_valid, "result dropped while stalled")

    // A waiting result keeps its payload
    `SOIFS_CHECK(a_res_stable, i_res_valid && !i_res_ready |=> $stable(i_status) && $stable(i_value_end), "stalled result changed")

    // No result comes out of reset
    `SOIFS_CHECK_ALWAYS(a_reset_empty, !i_rst_n |=> !i_res_valid, "result valid after reset")

    // With both buffer entries full and nothing drained, input stays blocked
    `SOIFS_CHECK(a_full_blocks, i_res_valid && !i_res_ready && !i_req_ready |=> !i_req_ready, "request taken while buffer full")

endmodule

bind soif_attribute_scanner_core soifs_checker u_soifs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_value_end (o_res.value_end)
);
